// ===== rtl/core/sgg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Serpentine gait generator package
// Sizes, register map, port widths and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package sgg_pkg;

  localparam int JOINTS           = 12;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int JNT_W   = $clog2(JOINTS);
  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IDXP_W  = 15 + IDX_W;
  localparam int PH_W    = 16;
  localparam int AMP_W   = 14;
  localparam int SIN_W   = 16;
  localparam int DIG_W   = 4;
  localparam int N_DIG   = SIN_W / DIG_W;
  localparam int DCNT_W  = $clog2(N_DIG);
  localparam int PROD_W  = SIN_W + AMP_W;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_PHASE_INC,
    REG_VSTEP,
    REG_HSTEP,
    REG_HDELTA,
    REG_VAMP,
    REG_HAMP,
    REG_OFFSET,
    REG_STIFF
  } cfg_reg_t;

  localparam logic [63:0] Q30_A1  = 64'd1686629713;
  localparam logic [63:0] Q30_A3  = 64'd693598669;
  localparam logic [63:0] Q30_A5  = 64'd85569306;
  localparam logic [63:0] Q30_A7  = 64'd5026995;
  localparam logic [63:0] Q30_A9  = 64'd172272;
  localparam logic [63:0] Q30_A11 = 64'd3864;

  typedef logic [SIN_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // Q15 entry from an odd Taylor polynomial in Q30
  function automatic logic [SIN_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = (64'(k) << 30) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t  = Q30_A11;
    t  = Q30_A9 - ((x2 * t) >> 30);
    t  = Q30_A7 - ((x2 * t) >> 30);
    t  = Q30_A5 - ((x2 * t) >> 30);
    t  = Q30_A3 - ((x2 * t) >> 30);
    t  = Q30_A1 - ((x2 * t) >> 30);
    t  = (x * t) >> 30;
    return SIN_W'((t + 64'd16384) >> 15);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/serpentine_gait_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Serpentine gait generator
// Emits one position and stiffness command per joint for each tick beat.
// ----------------------------------------------------------------------------
// A tick beat on the in_ channel optionally advances the time phase and then
// produces JOINTS command beats on the out_ channel, joint 0 first, with tlast
// on the final joint. Each joint takes one registered sine table read, a
// 4-bit digit-serial amplitude multiplier and a step of rounding, offset
// and saturation that loads the output register; that step stalls while
// the output register holds a command that out_tready has not taken.
// The output register lets a new tick beat be accepted while the last
// command still waits. Write configuration only while no tick is in flight.
module serpentine_gait_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sgg_pkg::IN_TDATA_W-1:0]   in_tdata,   // advance, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sgg_pkg::OUT_TDATA_W-1:0]  out_tdata,  // joint_index, position,
                                                       // stiffness, zero pad
  output logic                             out_tlast,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [sgg_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sgg_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sgg_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  import sgg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_MUL,
    S_FIN
  } state_t;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [PH_W-1:0]       phase_inc_r;
  logic [PH_W-1:0]       vstep_r;
  logic [PH_W-1:0]       hstep_r;
  logic [PH_W-1:0]       hdelta_r;
  logic [AMP_W-1:0]      vamp_r;
  logic [AMP_W-1:0]      hamp_r;
  logic [31:0]           offset_r;
  logic [31:0]           stiff_r;

  state_t                state_r;
  logic [PH_W-1:0]       tphase_r;
  logic [PH_W-1:0]       hacc_r;
  logic [PH_W-1:0]       vacc_r;
  logic [JNT_W-1:0]      jnt_r;
  logic                  neg_r;
  logic [SIN_W-1:0]      mag_r;
  logic [PROD_W-1:0]     acc_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic                  cfg_wr;
  cfg_reg_t              cfg_sel;
  logic [PH_W-1:0]       tphase_nxt;
  logic                  odd;
  logic [PH_W-1:0]       phase;
  logic [14:0]           qq;
  logic [IDXP_W-1:0]     idx_prod;
  logic [IDX_W:0]        idx_full;
  logic [IDX_W-1:0]      tab_idx;
  logic [AMP_W-1:0]      amp;
  logic [PROD_W-1:0]     part;
  logic [PROD_W-1:0]     acc_nxt;
  logic [15:0]           rnd;
  logic signed [17:0]    scaled;
  logic [15:0]           off;
  logic signed [17:0]    sum;
  logic [15:0]           pos;
  logic [15:0]           stiff;
  logic                  jnt_last;
  logic                  out_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      vstep_r     <= '0;
      hstep_r     <= '0;
      hdelta_r    <= '0;
      vamp_r      <= '0;
      hamp_r      <= '0;
      offset_r    <= '0;
      stiff_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PHASE_INC: phase_inc_r <= cfg_pwdata[PH_W-1:0];
        REG_VSTEP:     vstep_r     <= cfg_pwdata[PH_W-1:0];
        REG_HSTEP:     hstep_r     <= cfg_pwdata[PH_W-1:0];
        REG_HDELTA:    hdelta_r    <= cfg_pwdata[PH_W-1:0];
        REG_VAMP:      vamp_r      <= cfg_pwdata[AMP_W-1:0];
        REG_HAMP:      hamp_r      <= cfg_pwdata[AMP_W-1:0];
        REG_OFFSET:    offset_r    <= cfg_pwdata;
        REG_STIFF:     stiff_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PHASE_INC: cfg_prdata = CFG_DATA_W'(phase_inc_r);
      REG_VSTEP:     cfg_prdata = CFG_DATA_W'(vstep_r);
      REG_HSTEP:     cfg_prdata = CFG_DATA_W'(hstep_r);
      REG_HDELTA:    cfg_prdata = CFG_DATA_W'(hdelta_r);
      REG_VAMP:      cfg_prdata = CFG_DATA_W'(vamp_r);
      REG_HAMP:      cfg_prdata = CFG_DATA_W'(hamp_r);
      REG_OFFSET:    cfg_prdata = offset_r;
      REG_STIFF:     cfg_prdata = stiff_r;
      default:       cfg_prdata = '0;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign tphase_nxt = in_tdata[0] ? tphase_r + phase_inc_r : tphase_r;

  assign odd      = jnt_r[0];
  assign phase    = odd ? vacc_r : hacc_r;
  assign qq       = phase[14] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
  assign idx_prod = IDXP_W'(qq) * IDXP_W'(SINE_TABLE_DEPTH) + IDXP_W'(8192);
  assign idx_full = idx_prod[IDXP_W-1:14];
  assign tab_idx  = (idx_full > (IDX_W+1)'(SINE_TABLE_DEPTH)) ?
                    IDX_W'(SINE_TABLE_DEPTH) : idx_full[IDX_W-1:0];

  assign amp      = odd ? vamp_r : hamp_r;
  assign part     = PROD_W'(amp) * PROD_W'(mag_r[SIN_W-1 -: DIG_W]);
  assign acc_nxt  = (acc_r << DIG_W) + part;

  assign rnd      = 16'((acc_r + PROD_W'(16384)) >> 15);
  assign scaled   = neg_r ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
  assign off      = odd ? offset_r[31:16] : offset_r[15:0];
  assign sum      = $signed({{2{off[15]}}, off}) + scaled;
  assign pos      = (sum > 18'sd32767)  ? 16'h7fff :
                    (sum < -18'sd32768) ? 16'h8000 : sum[15:0];
  assign stiff    = odd ? stiff_r[31:16] : stiff_r[15:0];
  assign jnt_last = (jnt_r == JNT_W'(JOINTS - 1));
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tphase_r    <= '0;
      jnt_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            tphase_r <= tphase_nxt;
            hacc_r   <= tphase_nxt + hdelta_r;
            vacc_r   <= tphase_nxt + vstep_r;
            jnt_r    <= '0;
            state_r  <= S_ADDR;
          end
        end
        S_ADDR: begin
          mag_r   <= SINE_TAB[tab_idx];
          neg_r   <= phase[15];
          acc_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r  <= acc_nxt;
          mag_r  <= mag_r << DIG_W;
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(N_DIG - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= {4'b0000, stiff, pos, 4'(jnt_r)};
            out_last_r  <= jnt_last;
            if (jnt_last) begin
              state_r <= S_IDLE;
            end else begin
              jnt_r <= jnt_r + 1'b1;
              if (odd) begin
                vacc_r <= vacc_r + PH_W'({vstep_r, 1'b0});
              end else begin
                hacc_r <= hacc_r + PH_W'({hstep_r, 1'b0});
              end
              state_r <= S_ADDR;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_tick_starts_joint0: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_ADDR && jnt_r == '0)
    else $error("tick beat did not start at joint 0");

  a_last_on_final_joint: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == 4'(JOINTS - 1))
    else $error("tlast on a joint other than the final one");

  a_sine_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADDR |=> mag_r <= 16'd32768)
    else $error("sine table magnitude above unity");
`endif

endmodule
`default_nettype wire
